// ===== sv/bb3_pkg.sv =====
// bb3_pkg: shared types, constants and the divide-by-nine helper for the 3x3 box blur
// used by the line memory, the window stage, the top level and the port checker
// no dependencies
package bb3_pkg;

    localparam int PIX_BITS        = 8;
    localparam int LINE_DATA_BITS  = 2 * PIX_BITS;   // {row r-2, row r-1}
    localparam int COLSUM_BITS     = PIX_BITS + 2;   // sum of three pixels
    localparam int SUM_BITS        = PIX_BITS + 4;   // sum of nine pixels
    localparam int ROW_BITS        = 16;
    localparam int COL_OUT_BITS    = 11;
    localparam int WIDTH_REG_BITS  = 12;
    localparam int HEIGHT_REG_BITS = 16;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 16;
    localparam int OUT_FIELD_BITS  = PIX_BITS + ROW_BITS + COL_OUT_BITS;
    localparam int OUT_TDATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // register indexes of the configuration channel
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 16'd480;
    localparam int DIM_MIN = 3;

    // ceil(2^16 / 9); exact floor quotient for every sum below 2^15
    localparam int RECIP_SHIFT = 16;
    localparam logic [12:0] RECIP9 = 13'd7282;

    typedef struct packed {
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        logic                    last;
    } pos_t;

    function automatic logic [PIX_BITS-1:0] div9(input logic [SUM_BITS-1:0] sum);
        logic [SUM_BITS+12:0] prod;
        prod = (SUM_BITS + 13)'(sum) * (SUM_BITS + 13)'(RECIP9);
        return prod[RECIP_SHIFT +: PIX_BITS];
    endfunction

endpackage

// ===== sv/bb3_line_mem.sv =====
// bb3_line_mem: single-port-write, single-port-read line buffer with registered read
// holds the two rows above the current row, one word per column
// depends on bb3_pkg
module bb3_line_mem #(
    parameter int DEPTH      = 2048,
    parameter int ADDR_BITS  = $clog2(DEPTH)
) (
    input  logic                                clk,
    input  logic                                rd_en,
    input  logic [ADDR_BITS-1:0]                rd_addr,
    output logic [bb3_pkg::LINE_DATA_BITS-1:0]  rd_data,
    input  logic                                wr_en,
    input  logic [ADDR_BITS-1:0]                wr_addr,
    input  logic [bb3_pkg::LINE_DATA_BITS-1:0]  wr_data
);

    logic [bb3_pkg::LINE_DATA_BITS-1:0] mem [DEPTH];
    logic [bb3_pkg::LINE_DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/bb3_window.sv =====
// bb3_window: 3x3 window kept as two registered column sums plus the incoming column
// produces the nine-pixel sum of the current neighborhood
// depends on bb3_pkg
module bb3_window (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic [bb3_pkg::PIX_BITS-1:0]   top,
    input  logic [bb3_pkg::PIX_BITS-1:0]   mid,
    input  logic [bb3_pkg::PIX_BITS-1:0]   bot,
    output logic [bb3_pkg::SUM_BITS-1:0]   sum
);

    logic [bb3_pkg::COLSUM_BITS-1:0] col_new;
    logic [bb3_pkg::COLSUM_BITS-1:0] col_m1_reg, col_m1_next;
    logic [bb3_pkg::COLSUM_BITS-1:0] col_m2_reg, col_m2_next;

    always_comb
    begin
        col_new = bb3_pkg::COLSUM_BITS'(top) + bb3_pkg::COLSUM_BITS'(mid)
                + bb3_pkg::COLSUM_BITS'(bot);
        sum = bb3_pkg::SUM_BITS'(col_m2_reg) + bb3_pkg::SUM_BITS'(col_m1_reg)
            + bb3_pkg::SUM_BITS'(col_new);
        col_m1_next = adv ? col_new : col_m1_reg;
        col_m2_next = adv ? col_m1_reg : col_m2_reg;
    end

    // window starts out all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_m1_reg <= '0;
            col_m2_reg <= '0;
        end
        else
        begin
            col_m1_reg <= col_m1_next;
            col_m2_reg <= col_m2_next;
        end
    end

endmodule

// ===== sv/box_blur_3x3_stream.sv =====
// box_blur_3x3_stream: streaming 3x3 mean filter with line buffers in one memory
// depends on bb3_pkg, bb3_line_mem and bb3_window
//
// usage
//   pixels enter in raster order on the s_ channel, one 8-bit word per beat
//   frame size comes from the cfg channel: index 0 image_width, index 1 image_height
//   cfg_ready is always high; write only while no pixel is in flight
//   each interior pixel gives one word on the m_ channel: the floor of the mean of
//   its 3x3 neighborhood, its row and column; border pixels give nothing
//   m_tlast marks the last interior pixel; the counters then wrap to the next frame
// throughput and pipeline
//   one pixel per clock sustained while m_tready stays high; the line memory is read
//   when a pixel is taken and written back when it leaves stage 1, and consecutive
//   pixels never share a column
//   a result passes registered stages for memory read, window sum, divide by nine
// reset and stalls
//   reset clears counters, window and pipeline valids and loads 640 x 480;
//   line memory contents stay undefined until the first rows have passed
//   when m_tready is low the output word holds and the stages behind it fill,
//   then s_tready drops; no word is lost or repeated
module box_blur_3x3_stream #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // pixel input; s_tdata: [7:0] pixel
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [bb3_pkg::PIX_BITS-1:0]            s_tdata,
    // blurred output; m_tdata: [7:0] blurred, [23:8] out_row, [34:24] out_col,
    // [39:35] zero
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [bb3_pkg::OUT_TDATA_BITS-1:0]      m_tdata,
    output logic                                    m_tlast,   // frame_last
    // register writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [bb3_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
    input  logic [bb3_pkg::CFG_DATA_BITS-1:0]       cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);                 // column counter / address
    localparam int WW = (CW + 1 > bb3_pkg::WIDTH_REG_BITS) ? CW + 1
                                                          : bb3_pkg::WIDTH_REG_BITS;
    localparam int RB = bb3_pkg::ROW_BITS;

    // configuration
    logic [bb3_pkg::WIDTH_REG_BITS-1:0]  image_width_reg, image_width_next;
    logic [bb3_pkg::HEIGHT_REG_BITS-1:0] image_height_reg, image_height_next;

    // position of the next input pixel
    logic [CW-1:0] col_count_reg, col_count_next;
    logic [RB-1:0] row_count_reg, row_count_next;

    // stage 1: memory read in flight
    logic                    s1_valid_reg, s1_valid_next;
    logic                    s1_hit_reg;
    logic [CW-1:0]           s1_addr_reg;
    logic [bb3_pkg::PIX_BITS-1:0] s1_pix_reg;
    bb3_pkg::pos_t           s1_pos_reg;

    // stage 2: window sum
    logic                    s2_valid_reg, s2_valid_next;
    logic [bb3_pkg::SUM_BITS-1:0] s2_sum_reg;
    bb3_pkg::pos_t           s2_pos_reg;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic [bb3_pkg::PIX_BITS-1:0] out_pix_reg;
    bb3_pkg::pos_t           out_pos_reg;

    // handshake and pipeline control
    logic accept, cfg_write;
    logic out_free, s2_free, s1_go;

    // frame geometry
    logic [WW-1:0] wid_ext, w_eff, col_last, col_ext, col_m1;
    logic [RB-1:0] h_eff, row_last, row_m1;
    logic          col_end, row_end, hit;
    bb3_pkg::pos_t pos_in;

    // line memory and window
    logic [bb3_pkg::LINE_DATA_BITS-1:0] line_rd;
    logic [bb3_pkg::PIX_BITS-1:0]       line_top, line_mid;
    logic [bb3_pkg::SUM_BITS-1:0]       win_sum;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign out_free = !out_valid_reg || m_tready;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s_tready = !s1_valid_reg || s2_free;
    assign accept   = s_tvalid && s_tready;

    // effective frame size: width clamped to [3, MAX_WIDTH], height at least 3
    always_comb
    begin
        wid_ext = WW'(image_width_reg);
        if (wid_ext < WW'(bb3_pkg::DIM_MIN))
        begin
            w_eff = WW'(bb3_pkg::DIM_MIN);
        end
        else if (wid_ext > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = wid_ext;
        end
        if (image_height_reg < RB'(bb3_pkg::DIM_MIN))
        begin
            h_eff = RB'(bb3_pkg::DIM_MIN);
        end
        else
        begin
            h_eff = image_height_reg;
        end
        col_last = w_eff - WW'(1);
        row_last = h_eff - RB'(1);
        col_ext  = WW'(col_count_reg);
        // "at or past the last" so a shrunk frame wraps on the next pixel
        col_end  = col_ext >= col_last;
        row_end  = row_count_reg >= row_last;
        hit      = (row_count_reg >= RB'(2)) && (col_ext >= WW'(2));
        col_m1   = col_ext - WW'(1);
        row_m1   = row_count_reg - RB'(1);
        pos_in.row  = row_m1;
        pos_in.col  = col_m1[bb3_pkg::COL_OUT_BITS-1:0];
        pos_in.last = col_end && row_end;
    end

    // counters and register writes
    always_comb
    begin
        col_count_next    = col_count_reg;
        row_count_next    = row_count_reg;
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (accept)
        begin
            if (col_end)
            begin
                col_count_next = '0;
                row_count_next = row_end ? '0 : row_count_reg + RB'(1);
            end
            else
            begin
                col_count_next = col_count_reg + CW'(1);
            end
        end
        if (cfg_write)
        begin
            case (cfg_index)
                bb3_pkg::REG_IMAGE_WIDTH:
                begin
                    image_width_next = cfg_data[bb3_pkg::WIDTH_REG_BITS-1:0];
                end
                bb3_pkg::REG_IMAGE_HEIGHT:
                begin
                    image_height_next = cfg_data[bb3_pkg::HEIGHT_REG_BITS-1:0];
                end
                default:
                begin
                    image_width_next = image_width_reg;
                end
            endcase
        end
    end

    // stage valids: border pixels leave stage 1 without entering stage 2
    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_go ? s1_hit_reg : (out_free ? 1'b0 : s2_valid_reg);
        out_valid_next = out_free ? s2_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= bb3_pkg::WIDTH_RESET;
            image_height_reg <= bb3_pkg::HEIGHT_RESET;
            col_count_reg    <= '0;
            row_count_reg    <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            col_count_reg    <= col_count_next;
            row_count_reg    <= row_count_next;
            s1_valid_reg     <= s1_valid_next;
            s2_valid_reg     <= s2_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_hit_reg  <= hit;
            s1_addr_reg <= col_count_reg;
            s1_pix_reg  <= s_tdata;
            s1_pos_reg  <= pos_in;
        end
        if (s1_go)
        begin
            s2_sum_reg <= win_sum;
            s2_pos_reg <= s1_pos_reg;
        end
        if (out_free)
        begin
            out_pix_reg <= bb3_pkg::div9(s2_sum_reg);
            out_pos_reg <= s2_pos_reg;
        end
    end

    // read at accept, write back {mid, bot} when the pixel leaves stage 1;
    // consecutive pixels always address different columns
    bb3_line_mem #(
        .DEPTH     (MAX_WIDTH),
        .ADDR_BITS (CW)
    ) u_line_mem (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_count_reg),
        .rd_data (line_rd),
        .wr_en   (s1_go),
        .wr_addr (s1_addr_reg),
        .wr_data ({line_mid, s1_pix_reg})
    );

    assign line_top = line_rd[bb3_pkg::LINE_DATA_BITS-1:bb3_pkg::PIX_BITS];
    assign line_mid = line_rd[bb3_pkg::PIX_BITS-1:0];

    bb3_window u_window (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (s1_go),
        .top   (line_top),
        .mid   (line_mid),
        .bot   (s1_pix_reg),
        .sum   (win_sum)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_pos_reg.last;
    assign m_tdata  = {(bb3_pkg::OUT_TDATA_BITS - bb3_pkg::OUT_FIELD_BITS)'(0),
                       out_pos_reg.col, out_pos_reg.row, out_pix_reg};

endmodule

// ===== sv/bb3_checker.sv =====
// bb3_checker: port-level assertions for the 3x3 box blur, bound to the top level
// depends on bb3_pkg and box_blur_3x3_stream
module bb3_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [bb3_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    input  logic                                m_tlast
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // fill bits above the packed fields stay zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[bb3_pkg::OUT_TDATA_BITS-1:bb3_pkg::OUT_FIELD_BITS] == '0)
        else $error("output fill bits not zero");

    // only interior pixels come out: row and column never zero
    a_out_interior: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:8] != 16'd0 && m_tdata[34:24] != 11'd0)
        else $error("border position on output");

    // right after an accepted frame end, a valid word is never a frame end on column zero
    a_last_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !(m_tvalid && m_tlast && m_tdata[34:24] == 11'd0))
        else $error("frame end flag on column zero");

endmodule

bind box_blur_3x3_stream bb3_checker u_bb3_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for the streaming 3x3 box blur, built around a per-pixel
// predictor of line buffers, window and frame counters; depends on bb3_pkg and
// box_blur_3x3_stream
`timescale 1ns / 1ps

module tb_top;

    localparam int LINE_DEPTH   = 2048;   // line buffer depth of the instance
    localparam int DRAIN_CYCLES = 8;      // quiet cycles before a register write
    localparam int RAND_PIXELS  = 700;    // least number of pixels in the random frames
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 400;    // long output hold-off
    localparam int HOLD_AFTER   = 100;    // results seen before the hold-off starts
    localparam int TAIL_CYCLES  = 20;

    typedef enum logic {ITEM_PIXEL, ITEM_CFG} item_kind_e;
    typedef enum logic [1:0] {PIX_CONST, PIX_UNIFORM, PIX_EXTREME, PIX_FLAT} pix_mode_e;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_EVERY_FOURTH, RDY_MOSTLY} rdy_mode_e;

    typedef struct {
        item_kind_e                         kind;
        logic [bb3_pkg::CFG_INDEX_BITS-1:0] reg_index;
        logic [bb3_pkg::CFG_DATA_BITS-1:0]  value;
        logic [bb3_pkg::PIX_BITS-1:0]       pixel;
    } stim_item_t;

    typedef struct {
        logic [bb3_pkg::PIX_BITS-1:0]     blurred;
        logic [bb3_pkg::ROW_BITS-1:0]     row;
        logic [bb3_pkg::COL_OUT_BITS-1:0] col;
        logic                             last;
    } blur_result_t;

    // dut ports
    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               s_tvalid  = 1'b0;
    logic                               s_tready;
    logic [bb3_pkg::PIX_BITS-1:0]       s_tdata   = '0;   // [7:0] pixel
    logic                               m_tvalid;
    logic                               m_tready  = 1'b0;
    logic [bb3_pkg::OUT_TDATA_BITS-1:0] m_tdata;          // [7:0] blurred, [23:8] row,
                                                          // [34:24] col, [39:35] zero
    logic                               m_tlast;          // frame_last
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [bb3_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [bb3_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // work queues
    stim_item_t   stim_q[$];       // words still to offer, in order
    blur_result_t blur_due_q[$];   // blurred pixels predicted but not yet seen

    // handshakes seen at the last rising edge, used by the falling-edge driver
    logic s_acc   = 1'b0;
    logic cfg_acc = 1'b0;

    int err_count    = 0;
    int results_seen = 0;

    // predictor state: registers, line buffers, window and position counters
    int                           width_reg  = int'(bb3_pkg::WIDTH_RESET);
    int                           height_reg = int'(bb3_pkg::HEIGHT_RESET);
    logic [bb3_pkg::PIX_BITS-1:0] line_up1[LINE_DEPTH];   // row r-1
    logic [bb3_pkg::PIX_BITS-1:0] line_up2[LINE_DEPTH];   // row r-2
    logic [bb3_pkg::PIX_BITS-1:0] win_cols[6];   // columns c-2, c-1 as top, mid, bottom
    int                           col_cnt = 0;
    int                           row_cnt = 0;

    box_blur_3x3_stream #(
        .MAX_WIDTH (LINE_DEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // out-of-range sizes act as the nearest legal one
    function automatic int clamp_width(input int value);
        if (value < bb3_pkg::DIM_MIN)
            return bb3_pkg::DIM_MIN;
        if (value > LINE_DEPTH)
            return LINE_DEPTH;
        return value;
    endfunction

    function automatic int clamp_height(input int value);
        return (value < bb3_pkg::DIM_MIN) ? bb3_pkg::DIM_MIN : value;
    endfunction

    // advance the blur state by one pixel; returns 1 when an interior result is due
    function automatic bit predict_blur(input logic [bb3_pkg::PIX_BITS-1:0] pix,
                                        output blur_result_t res);
        int                           w;
        int                           h;
        int                           idx;
        int                           sum;
        int                           k;
        logic [bb3_pkg::PIX_BITS-1:0] mid;
        logic [bb3_pkg::PIX_BITS-1:0] top;
        bit                           col_end;
        bit                           row_end;
        bit                           hit;
        w       = clamp_width(width_reg);
        h       = clamp_height(height_reg);
        idx     = col_cnt % LINE_DEPTH;
        mid     = line_up1[idx];
        top     = line_up2[idx];
        // "at or past the last" so a shrunk frame wraps on the next pixel
        col_end = (col_cnt >= w - 1);
        row_end = (row_cnt >= h - 1);
        hit     = (row_cnt >= 2) && (col_cnt >= 2);
        res     = '{default: '0};
        if (hit)
        begin
            sum = int'(top) + int'(mid) + int'(pix);
            for (k = 0; k < 6; k++)
                sum += int'(win_cols[k]);
            res.blurred = bb3_pkg::PIX_BITS'(sum / 9);
            res.row     = bb3_pkg::ROW_BITS'(row_cnt - 1);
            res.col     = bb3_pkg::COL_OUT_BITS'(col_cnt - 1);
            res.last    = col_end && row_end;
        end
        line_up2[idx] = mid;
        line_up1[idx] = pix;
        win_cols[0]   = win_cols[3];
        win_cols[1]   = win_cols[4];
        win_cols[2]   = win_cols[5];
        win_cols[3]   = top;
        win_cols[4]   = mid;
        win_cols[5]   = pix;
        if (col_end)
        begin
            col_cnt = 0;
            row_cnt = row_end ? 0 : row_cnt + 1;
        end
        else
        begin
            col_cnt = col_cnt + 1;
        end
        return hit;
    endfunction

    task automatic push_cfg(input logic [bb3_pkg::CFG_INDEX_BITS-1:0] idx,
                            input logic [bb3_pkg::CFG_DATA_BITS-1:0] value);
        stim_item_t it;
        it.kind      = ITEM_CFG;
        it.reg_index = idx;
        it.value     = value;
        it.pixel     = '0;
        stim_q.push_back(it);
    endtask

    task automatic push_pixels(input int count, input pix_mode_e mode,
                               input logic [bb3_pkg::PIX_BITS-1:0] fill);
        stim_item_t                   it;
        logic [bb3_pkg::PIX_BITS-1:0] base;
        int                           i;
        base = bb3_pkg::PIX_BITS'($urandom_range(0, 255));
        for (i = 0; i < count; i++)
        begin
            it.kind      = ITEM_PIXEL;
            it.reg_index = '0;
            it.value     = '0;
            case (mode)
                PIX_CONST:   it.pixel = fill;
                PIX_EXTREME: it.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                // small ripple around one level, exercises the floor of the divide
                PIX_FLAT:    it.pixel = (base & 8'hFC)
                                        | bb3_pkg::PIX_BITS'($urandom_range(0, 3));
                default:     it.pixel = bb3_pkg::PIX_BITS'($urandom_range(0, 255));
            endcase
            stim_q.push_back(it);
        end
    endtask

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%s", msg);
    endtask

    // sender: bursts of random length with random gaps, register writes only
    // once the pipeline has drained
    int burst_left = 1;
    int gap_left   = 0;
    int quiet_cnt  = 0;

    always @(negedge clk)
    begin
        logic       nxt_valid;
        logic       nxt_cfg;
        stim_item_t it;
        nxt_valid = 1'b0;
        nxt_cfg   = 1'b0;
        if (rst_n)
        begin
            // idle cycles since the last pixel word and result
            if (blur_due_q.size() == 0 && !m_tvalid && !s_acc && !s_tvalid)
                quiet_cnt++;
            else
                quiet_cnt = 0;

            if (s_tvalid && !s_acc)
                nxt_valid = 1'b1;               // word still waiting for s_tready
            else if (cfg_valid && !cfg_acc)
                nxt_cfg = 1'b1;                 // register write still waiting
            else if (stim_q.size() != 0)
            begin
                if (stim_q[0].kind == ITEM_CFG)
                begin
                    // pixels without a result may still be in flight
                    if (quiet_cnt >= DRAIN_CYCLES)
                    begin
                        it        = stim_q.pop_front();
                        cfg_index <= it.reg_index;
                        cfg_data  <= it.value;
                        nxt_cfg   = 1'b1;
                        quiet_cnt = 0;
                    end
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                end
                else
                begin
                    it        = stim_q.pop_front();
                    s_tdata   <= it.pixel;
                    nxt_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                                 : $urandom_range(1, 40);
                    end
                end
            end
            s_tvalid  <= nxt_valid;
            cfg_valid <= nxt_cfg;
        end
    end

    // receiver: one long hold-off to back the pipeline up into s_tready,
    // otherwise a changing ready pattern
    int        hold_left = 0;
    bit        hold_done = 1'b0;
    int        mode_left = 0;
    int        rdy_phase = 0;
    rdy_mode_e rdy_mode  = RDY_ALWAYS;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rdy_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                if (mode_left <= 0)
                begin
                    rdy_mode  = rdy_mode_e'($urandom_range(0, 3));
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (rdy_mode)
                    RDY_COIN:         m_tready <= ($urandom_range(0, 1) == 1);
                    RDY_EVERY_FOURTH: m_tready <= (rdy_phase % 4 == 0);
                    RDY_MOSTLY:       m_tready <= ($urandom_range(0, 9) != 0);
                    default:          m_tready <= 1'b1;
                endcase
            end
        end
    end

    // monitor: register writes, result checking, prediction of accepted pixels
    always @(posedge clk)
    begin
        blur_result_t got;
        blur_result_t want;
        if (!rst_n)
        begin
            s_acc   <= 1'b0;
            cfg_acc <= 1'b0;
        end
        else
        begin
            s_acc   <= s_tvalid && s_tready;
            cfg_acc <= cfg_valid && cfg_ready;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == bb3_pkg::REG_IMAGE_WIDTH)
                    width_reg = int'(cfg_data[bb3_pkg::WIDTH_REG_BITS-1:0]);
                else if (cfg_index == bb3_pkg::REG_IMAGE_HEIGHT)
                    height_reg = int'(cfg_data[bb3_pkg::HEIGHT_REG_BITS-1:0]);
            end

            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got.blurred = m_tdata[0 +: bb3_pkg::PIX_BITS];
                got.row     = m_tdata[bb3_pkg::PIX_BITS +: bb3_pkg::ROW_BITS];
                got.col     = m_tdata[bb3_pkg::PIX_BITS + bb3_pkg::ROW_BITS
                                      +: bb3_pkg::COL_OUT_BITS];
                got.last    = m_tlast;
                if (blur_due_q.size() == 0)
                    flag_error($sformatf("unexpected result: blurred=%0d row=%0d col=%0d last=%0b",
                                         got.blurred, got.row, got.col, got.last));
                else
                begin
                    want = blur_due_q.pop_front();
                    if (got.blurred !== want.blurred || got.row !== want.row ||
                        got.col !== want.col || got.last !== want.last ||
                        m_tdata[bb3_pkg::OUT_TDATA_BITS-1:bb3_pkg::OUT_FIELD_BITS] !== '0)
                        flag_error($sformatf({"mismatch: want blurred=%0d row=%0d col=%0d ",
                                              "last=%0b, got blurred=%0d row=%0d col=%0d ",
                                              "last=%0b pad=%h"},
                                             want.blurred, want.row, want.col, want.last,
                                             got.blurred, got.row, got.col, got.last,
                                             m_tdata[bb3_pkg::OUT_TDATA_BITS-1:
                                                     bb3_pkg::OUT_FIELD_BITS]));
                end
            end

            if (s_tvalid && s_tready)
            begin
                if (predict_blur(s_tdata, want))
                    blur_due_q.push_back(want);
            end
        end
    end

    // stimulus plan, then reset, then wait for the pipeline to drain
    initial
    begin
        int        i;
        int        rand_count;
        int        wv;
        int        hv;
        int        frames;
        int        f;
        pix_mode_e mode;

        for (i = 0; i < LINE_DEPTH; i++)
        begin
            line_up1[i] = '0;
            line_up2[i] = '0;
        end
        for (i = 0; i < 6; i++)
            win_cols[i] = '0;

        // reset size 640 x 480: one full row wraps at column 639, then the frame
        // shrinks to 5 x 3 mid-row and row 2 closes it
        push_pixels(640 + 3, PIX_UNIFORM, '0);
        push_cfg(bb3_pkg::REG_IMAGE_WIDTH, 16'd5);
        push_cfg(bb3_pkg::REG_IMAGE_HEIGHT, 16'd3);
        push_pixels(2 + 5, PIX_UNIFORM, '0);

        // sizes below the minimum act as 3 x 3: all-white, all-black, extremes
        push_cfg(bb3_pkg::REG_IMAGE_WIDTH, 16'd0);
        push_cfg(bb3_pkg::REG_IMAGE_HEIGHT, 16'd2);
        push_pixels(9, PIX_CONST, 8'hFF);
        push_pixels(9, PIX_CONST, 8'h00);
        push_pixels(9, PIX_EXTREME, '0);

        // tallest frame, cut short mid-row by a smaller height
        push_cfg(bb3_pkg::REG_IMAGE_WIDTH, 16'd8);
        push_cfg(bb3_pkg::REG_IMAGE_HEIGHT, 16'hFFFF);
        push_pixels(8 * 5 + 3, PIX_UNIFORM, '0);
        push_cfg(bb3_pkg::REG_IMAGE_HEIGHT, 16'd3);
        push_pixels(5, PIX_UNIFORM, '0);

        // width shrinks mid-row below the current column: wraps at once
        push_cfg(bb3_pkg::REG_IMAGE_WIDTH, 16'd10);
        push_cfg(bb3_pkg::REG_IMAGE_HEIGHT, 16'd6);
        push_pixels(36, PIX_UNIFORM, '0);
        push_cfg(bb3_pkg::REG_IMAGE_WIDTH, 16'd5);
        push_pixels(11, PIX_UNIFORM, '0);

        // random small frames, sizes changed only at frame boundaries
        rand_count = 0;
        while (rand_count < RAND_PIXELS)
        begin
            case ($urandom_range(0, 7))
                0:       wv = $urandom_range(0, 2);
                1:       wv = 3;
                default: wv = $urandom_range(3, 24);
            endcase
            case ($urandom_range(0, 7))
                0:       hv = $urandom_range(0, 2);
                1:       hv = 3;
                default: hv = $urandom_range(3, 10);
            endcase
            if ($urandom_range(0, 1))
            begin
                push_cfg(bb3_pkg::REG_IMAGE_WIDTH,
                         bb3_pkg::CFG_DATA_BITS'(wv | ($urandom_range(0, 15) << 12)));
                push_cfg(bb3_pkg::REG_IMAGE_HEIGHT, bb3_pkg::CFG_DATA_BITS'(hv));
            end
            else
            begin
                push_cfg(bb3_pkg::REG_IMAGE_HEIGHT, bb3_pkg::CFG_DATA_BITS'(hv));
                push_cfg(bb3_pkg::REG_IMAGE_WIDTH, bb3_pkg::CFG_DATA_BITS'(wv));
            end
            frames = $urandom_range(1, 2);
            for (f = 0; f < frames; f++)
            begin
                case ($urandom_range(0, 5))
                    0:       mode = PIX_EXTREME;
                    1:       mode = PIX_FLAT;
                    default: mode = PIX_UNIFORM;
                endcase
                push_pixels(clamp_width(wv) * clamp_height(hv), mode, '0);
                rand_count += clamp_width(wv) * clamp_height(hv);
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (stim_q.size() != 0 || s_tvalid || cfg_valid)
            @(posedge clk);
        while (blur_due_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
